@@ rtl/swst_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swst_pkg
// Shared types and constants for the sliding window statistics block.
// ============================================================================
package swst_pkg;

  // Fixed widths of the result fields and the register port
  localparam int STAT_W     = 24;
  localparam int CNT_OUT_W  = 7;
  localparam int WLEN_W     = 7;
  localparam int BAND_W     = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  // Compare width wide enough for samples up to 25 bits and the band bounds
  localparam int CMP_W      = 25;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_WLEN    = 2'd0;
  localparam logic [1:0] REG_BAND_LO = 2'd1;
  localparam logic [1:0] REG_BAND_HI = 2'd2;

  // Register reset values
  localparam logic [WLEN_W-1:0] WLEN_RESET    = 7'd64;
  localparam logic [BAND_W-1:0] BAND_LO_RESET = 16'h8000;
  localparam logic [BAND_W-1:0] BAND_HI_RESET = 16'h7FFF;

  // Window controller states
  typedef enum logic [2:0] {
    W_IDLE,
    W_DROP_RD,
    W_DROP_SUB,
    W_APPEND,
    W_SCAN,
    W_WAIT,
    W_OUT
  } swst_wstate_t;

  // Arithmetic sequencer states
  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL,
    A_DIVM,
    A_FIXM,
    A_DIVV,
    A_FIXV,
    A_SQRT,
    A_DONE
  } swst_astate_t;

  // Status handed from the arithmetic unit to the window controller
  typedef struct packed {
    logic              done;
    logic [STAT_W-1:0] mean;
    logic [STAT_W-1:0] stddev;
  } swst_stat_t;

endpackage

@@ rtl/sliding_window_statistics.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sliding_window_statistics
// Count, mean, standard deviation, min, max and in-band count over a sliding
// window of the most recent samples.
// ============================================================================
// Usage:
//   in_*  : one sample per transaction (valid/ready); in_clear_first empties
//           the window before the sample is added.
//   out_* : exactly one result transaction per input, in order (valid/ready).
//   APB   : window_length at 0x0, band_low at 0x4, band_high at 0x8; write
//           only while no transaction is in flight.
// Before a sample is added, the oldest samples are evicted until the window
// is below its length (none while filling, one once full, more if the length
// drops). The arithmetic unit runs a serial multiply, two bit-serial divisions
// and a square root; the min/max rescan runs alongside it. One item is
// processed at a time; a two-entry input queue keeps taking transactions.
// Reset empties the window and loads window_length 64, band_low -32768 and
// band_high 32767. If out_ready is low the result holds in the output
// register and the back end waits; the input queue fills and then stalls.
// ============================================================================
module sliding_window_statistics #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  logic                                  in_clear_first,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [swst_pkg::CNT_OUT_W-1:0]        out_sample_count,
  output logic signed [swst_pkg::STAT_W-1:0]    out_mean_q8,
  output logic [swst_pkg::STAT_W-1:0]           out_stddev_q8,
  output logic signed [SAMPLE_BITS-1:0]         out_min_sample,
  output logic signed [SAMPLE_BITS-1:0]         out_max_sample,
  output logic [swst_pkg::CNT_OUT_W-1:0]        out_in_band_count,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [swst_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [swst_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [swst_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import swst_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int NW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = SAMPLE_BITS + AW + 1;
  localparam int QW = 2 * SAMPLE_BITS + AW;

  logic [WLEN_W-1:0]        wlen_r;
  logic signed [BAND_W-1:0] band_lo_r, band_hi_r;
  logic                     cfg_wr;

  logic                          q_valid, q_ready, q_clear;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  swst_stat_t                    stat;
  logic                          a_start, a_ack;
  logic [NW-1:0]                 a_n;
  logic signed [SW-1:0]          a_sum;
  logic [QW-1:0]                 a_sumsq;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= WLEN_RESET;
      band_lo_r <= BAND_LO_RESET;
      band_hi_r <= BAND_HI_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WLEN:    wlen_r    <= pwdata[WLEN_W-1:0];
        REG_BAND_LO: band_lo_r <= pwdata[BAND_W-1:0];
        REG_BAND_HI: band_hi_r <= pwdata[BAND_W-1:0];
        default:     wlen_r    <= wlen_r;
      endcase
    end
  end

  // Readback
  always_comb begin
    case (paddr[3:2])
      REG_WLEN:    prdata = CFG_DATA_W'(wlen_r);
      REG_BAND_LO: prdata = CFG_DATA_W'(band_lo_r);
      REG_BAND_HI: prdata = CFG_DATA_W'(band_hi_r);
      default:     prdata = '0;
    endcase
  end

  swst_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_clear_first (in_clear_first),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_sample       (q_sample),
    .q_clear        (q_clear)
  );

  swst_window #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_window (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (q_valid),
    .item_ready        (q_ready),
    .item_sample       (q_sample),
    .item_clear        (q_clear),
    .wlen              (wlen_r),
    .band_lo           (band_lo_r),
    .band_hi           (band_hi_r),
    .stat              (stat),
    .arith_start       (a_start),
    .arith_ack         (a_ack),
    .arith_n           (a_n),
    .arith_sum         (a_sum),
    .arith_sumsq       (a_sumsq),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_count  (out_sample_count),
    .out_mean_q8       (out_mean_q8),
    .out_stddev_q8     (out_stddev_q8),
    .out_min_sample    (out_min_sample),
    .out_max_sample    (out_max_sample),
    .out_in_band_count (out_in_band_count)
  );

  swst_arith #(.WINDOW_DEPTH(WINDOW_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (a_start),
    .ack   (a_ack),
    .n     (a_n),
    .sum   (a_sum),
    .sumsq (a_sumsq),
    .stat  (stat)
  );

endmodule

@@ rtl/swst_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swst_front
// Input stage: two-entry queue that takes transactions independently of the
// back end.
// ============================================================================
module swst_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_clear_first,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          q_clear
);
  import swst_pkg::*;

  logic signed [SAMPLE_BITS-1:0] samp_r [2];
  logic                          clr_r  [2];
  logic                          wr_ptr_r, wr_ptr_nxt;
  logic                          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                    count_r, count_nxt;
  logic                          push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_sample = samp_r[rd_ptr_r];
  assign q_clear  = clr_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      samp_r[wr_ptr_r] <= in_sample;
      clr_r[wr_ptr_r]  <= in_clear_first;
    end
  end

endmodule

@@ rtl/swst_arith.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swst_arith
// Mean and standard deviation from count, sum and sum of squares: shift-add
// multiply, restoring division and digit-by-digit square root.
// ============================================================================
module swst_arith #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 16,
  localparam int AW = $clog2(WINDOW_DEPTH),
  localparam int NW = $clog2(WINDOW_DEPTH + 1),
  localparam int MW = SAMPLE_BITS + AW,
  localparam int SW = MW + 1,
  localparam int QW = 2 * SAMPLE_BITS + AW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 ack,
  input  logic [NW-1:0]        n,
  input  logic signed [SW-1:0] sum,
  input  logic [QW-1:0]        sumsq,
  output swst_pkg::swst_stat_t stat
);
  import swst_pkg::*;

  localparam int VW   = 2 * MW;
  localparam int DW   = VW + 16;
  localparam int MDW  = MW + 8;
  localparam int REMW = 2 * NW + 1;
  localparam int RW   = SAMPLE_BITS + 8;
  localparam int XW   = 2 * RW;
  localparam int CTW  = $clog2(DW + 1);

  swst_astate_t state_r, state_nxt;
  logic [CTW-1:0]    cnt_r;
  logic              neg_r;
  logic [MW-1:0]     mag_r, mb_r, nb_r;
  logic [QW-1:0]     sumsq_r;
  logic [VW-1:0]     acc_sq_r, acc_nq_r;
  logic [NW-1:0]     n_r;
  logic [2*NW-1:0]   n2_r;
  logic [DW-1:0]     num_r, q_r;
  logic [REMW-1:0]   rem_r;
  logic [RW-1:0]     root_r;
  logic [RW+1:0]     srem_r;
  logic [XW-1:0]     x_r;
  logic [STAT_W-1:0] mean_r;

  logic [MW-1:0]      mag_in;
  logic [REMW-1:0]    trial, divisor, rem_step;
  logic               div_ge;
  logic [RW+1:0]      s2, s_trial;
  logic               sq_ge;
  logic [MDW:0]       mq;
  logic signed [MDW:0] mq_s;
  logic               last;

  assign mag_in = sum[SW-1] ? MW'(-sum) : MW'(sum);
  assign last   = (cnt_r == CTW'(1));

  // Restoring division step, shared by the mean and variance divisions
  always_comb begin
    divisor  = (state_r == A_DIVM) ? REMW'(n_r) : REMW'(n2_r);
    trial    = {rem_r[REMW-2:0], num_r[DW-1]};
    div_ge   = (trial >= divisor);
    rem_step = div_ge ? (trial - divisor) : trial;
  end

  // Square root step: two radicand bits per cycle
  always_comb begin
    s2      = {srem_r[RW-1:0], x_r[XW-1:XW-2]};
    s_trial = {root_r, 2'b01};
    sq_ge   = (s2 >= s_trial);
  end

  // Floored mean from quotient magnitude and remainder
  always_comb begin
    mq   = {1'b0, q_r[MDW-1:0]} + (MDW+1)'(neg_r && (rem_r != '0));
    mq_s = neg_r ? -$signed(mq) : $signed(mq);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      A_IDLE:  if (start) state_nxt = A_MUL;
      A_MUL:   if (last) state_nxt = A_DIVM;
      A_DIVM:  if (last) state_nxt = A_FIXM;
      A_FIXM:  state_nxt = A_DIVV;
      A_DIVV:  if (last) state_nxt = A_FIXV;
      A_FIXV:  state_nxt = A_SQRT;
      A_SQRT:  if (last) state_nxt = A_DONE;
      A_DONE:  if (ack) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      A_IDLE: begin
        n_r      <= n;
        n2_r     <= (2*NW)'(n) * (2*NW)'(n);
        neg_r    <= sum[SW-1];
        mag_r    <= mag_in;
        mb_r     <= mag_in;
        nb_r     <= MW'(n);
        sumsq_r  <= sumsq;
        acc_sq_r <= '0;
        acc_nq_r <= '0;
        cnt_r    <= CTW'(MW);
      end
      A_MUL: begin
        // MSB-first shift-add for sum^2 and n*sumsq
        acc_sq_r <= (acc_sq_r << 1) + (mb_r[MW-1] ? VW'(mag_r) : '0);
        acc_nq_r <= (acc_nq_r << 1) + (nb_r[MW-1] ? VW'(sumsq_r) : '0);
        mb_r     <= mb_r << 1;
        nb_r     <= nb_r << 1;
        cnt_r    <= cnt_r - CTW'(1);
        if (last) begin
          num_r <= DW'({mag_r, 8'd0}) << (DW - MDW);
          q_r   <= '0;
          rem_r <= '0;
          cnt_r <= CTW'(MDW);
        end
      end
      A_DIVM, A_DIVV: begin
        rem_r <= rem_step;
        num_r <= num_r << 1;
        q_r   <= {q_r[DW-2:0], div_ge};
        cnt_r <= cnt_r - CTW'(1);
      end
      A_FIXM: begin
        mean_r <= STAT_W'(mq_s);
        num_r  <= {acc_nq_r - acc_sq_r, 16'd0};
        q_r    <= '0;
        rem_r  <= '0;
        cnt_r  <= CTW'(DW);
      end
      A_FIXV: begin
        x_r    <= q_r[XW-1:0];
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= CTW'(RW);
      end
      A_SQRT: begin
        srem_r <= sq_ge ? (s2 - s_trial) : s2;
        root_r <= {root_r[RW-2:0], sq_ge};
        x_r    <= x_r << 2;
        cnt_r  <= cnt_r - CTW'(1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign stat.done   = (state_r == A_DONE);
  assign stat.mean   = mean_r;
  assign stat.stddev = STAT_W'(root_r);

endmodule

@@ rtl/swst_window.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swst_window
// Back end controller: ring store of samples, running sums, eviction of the
// oldest samples, min/max/band rescan and the result register.
// ============================================================================
module swst_window #(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 16,
  localparam int AW = $clog2(WINDOW_DEPTH),
  localparam int NW = $clog2(WINDOW_DEPTH + 1),
  localparam int SW = SAMPLE_BITS + AW + 1,
  localparam int QW = 2 * SAMPLE_BITS + AW
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  logic signed [SAMPLE_BITS-1:0]          item_sample,
  input  logic                                   item_clear,
  input  logic [swst_pkg::WLEN_W-1:0]            wlen,
  input  logic signed [swst_pkg::BAND_W-1:0]     band_lo,
  input  logic signed [swst_pkg::BAND_W-1:0]     band_hi,
  input  swst_pkg::swst_stat_t                   stat,
  output logic                                   arith_start,
  output logic                                   arith_ack,
  output logic [NW-1:0]                          arith_n,
  output logic signed [SW-1:0]                   arith_sum,
  output logic [QW-1:0]                          arith_sumsq,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [swst_pkg::CNT_OUT_W-1:0]         out_sample_count,
  output logic signed [swst_pkg::STAT_W-1:0]     out_mean_q8,
  output logic [swst_pkg::STAT_W-1:0]            out_stddev_q8,
  output logic signed [SAMPLE_BITS-1:0]          out_min_sample,
  output logic signed [SAMPLE_BITS-1:0]          out_max_sample,
  output logic [swst_pkg::CNT_OUT_W-1:0]         out_in_band_count
);
  import swst_pkg::*;

  localparam int NW1 = NW + 1;

  swst_wstate_t state_r, state_nxt;
  logic [AW-1:0]                 oldest_r;
  logic [NW-1:0]                 fill_r;
  logic signed [SW-1:0]          sum_r;
  logic [QW-1:0]                 sumsq_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic [NW-1:0]                 idx_r, band_r;
  logic                          rdv_r, first_r, start_r;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [AW-1:0]                 rd_addr;

  logic [NW-1:0]                 len;
  logic signed [2*SAMPLE_BITS-1:0] drop_sq, samp_sq;
  logic signed [CMP_W-1:0]       v_ext;
  logic                          in_band;

  // Ring position base+off, off never beyond the depth
  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                             input logic [NW-1:0] off);
    logic [NW1-1:0] t;
    t = NW1'(base) + NW1'(off);
    if (t >= NW1'(WINDOW_DEPTH)) t = t - NW1'(WINDOW_DEPTH);
    return AW'(t);
  endfunction

  // Effective window length: zero counts as one, saturate at the depth
  always_comb begin
    if (wlen == '0) len = NW'(1);
    else if (int'(wlen) > WINDOW_DEPTH) len = NW'(WINDOW_DEPTH);
    else len = NW'(wlen);
  end

  assign drop_sq = rd_data_r * rd_data_r;
  assign samp_sq = samp_r * samp_r;
  assign v_ext   = CMP_W'(rd_data_r);
  assign in_band = (v_ext > CMP_W'(band_lo)) && (v_ext < CMP_W'(band_hi));

  assign item_ready  = (state_r == W_IDLE);
  assign out_valid   = (state_r == W_OUT);
  assign arith_start = start_r;
  assign arith_ack   = (state_r == W_WAIT) && stat.done;
  assign arith_n     = fill_r;
  assign arith_sum   = sum_r;
  assign arith_sumsq = sumsq_r;
  assign rd_addr     = (state_r == W_SCAN) ? ring_idx(oldest_r, idx_r) : oldest_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      W_IDLE:     if (item_valid) state_nxt = W_DROP_RD;
      W_DROP_RD:  state_nxt = (fill_r >= len) ? W_DROP_SUB : W_APPEND;
      W_DROP_SUB: state_nxt = W_DROP_RD;
      W_APPEND:   state_nxt = W_SCAN;
      W_SCAN:     if (idx_r == fill_r && !rdv_r) state_nxt = W_WAIT;
      W_WAIT:     if (stat.done) state_nxt = W_OUT;
      W_OUT:      if (out_ready) state_nxt = W_IDLE;
      default:    state_nxt = W_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      oldest_r <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      sumsq_r  <= '0;
      start_r  <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == W_APPEND);
      case (state_r)
        W_IDLE: begin
          if (item_valid && item_clear) begin
            oldest_r <= '0;
            fill_r   <= '0;
            sum_r    <= '0;
            sumsq_r  <= '0;
          end
        end
        W_DROP_SUB: begin
          sum_r    <= sum_r - SW'(rd_data_r);
          sumsq_r  <= sumsq_r - QW'($unsigned(drop_sq));
          oldest_r <= ring_idx(oldest_r, NW'(1));
          fill_r   <= fill_r - NW'(1);
        end
        W_APPEND: begin
          sum_r   <= sum_r + SW'(samp_r);
          sumsq_r <= sumsq_r + QW'($unsigned(samp_sq));
          fill_r  <= fill_r + NW'(1);
          rdv_r   <= 1'b0;
        end
        W_SCAN: begin
          rdv_r <= (idx_r != fill_r);
        end
        default: begin
          rdv_r <= 1'b0;
        end
      endcase
    end
  end

  // Scan bookkeeping, sample latch and result register
  always_ff @(posedge clk) begin
    case (state_r)
      W_IDLE: begin
        samp_r <= item_sample;
      end
      W_APPEND: begin
        idx_r   <= '0;
        first_r <= 1'b1;
        band_r  <= '0;
      end
      W_SCAN: begin
        if (idx_r != fill_r) idx_r <= idx_r + NW'(1);
        if (rdv_r) begin
          first_r <= 1'b0;
          if (first_r || rd_data_r < min_r) min_r <= rd_data_r;
          if (first_r || rd_data_r > max_r) max_r <= rd_data_r;
          if (in_band) band_r <= band_r + NW'(1);
        end
      end
      W_WAIT: begin
        if (stat.done) begin
          out_sample_count  <= CNT_OUT_W'(fill_r);
          out_mean_q8       <= stat.mean;
          out_stddev_q8     <= stat.stddev;
          out_min_sample    <= min_r;
          out_max_sample    <= max_r;
          out_in_band_count <= CNT_OUT_W'(band_r);
        end
      end
      default: begin
        first_r <= first_r;
      end
    endcase
  end

  // Sample ring: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == W_APPEND) mem[ring_idx(oldest_r, fill_r)] <= samp_r;
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ rtl/swst_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swst_checker
// Port-level checks on the result channel of the statistics block.
// ============================================================================
module swst_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [swst_pkg::CNT_OUT_W-1:0]        out_sample_count,
  input logic signed [swst_pkg::STAT_W-1:0]    out_mean_q8,
  input logic signed [SAMPLE_BITS-1:0]         out_min_sample,
  input logic signed [SAMPLE_BITS-1:0]         out_max_sample,
  input logic [swst_pkg::CNT_OUT_W-1:0]        out_in_band_count
);
  import swst_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_q8))
    else $error("result dropped or changed while stalled");

  // A window is never empty when reported
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != '0)
    else $error("result with empty window");

  // Band count cannot exceed the window
  a_band_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_in_band_count <= out_sample_count)
    else $error("in-band count above sample count");

  // Minimum never above maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_sample <= out_max_sample)
    else $error("min above max");

endmodule

bind sliding_window_statistics swst_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sample_count  (out_sample_count),
  .out_mean_q8       (out_mean_q8),
  .out_min_sample    (out_min_sample),
  .out_max_sample    (out_max_sample),
  .out_in_band_count (out_in_band_count)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for sliding_window_statistics: a directed table and
// random sample streams, each result compared against a local window model.
// ============================================================================
module tb;
  import swst_pkg::*;

  localparam int DEPTH = 64;
  localparam int N_RANDOM = 1800;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_sample = '0;
  logic in_clear_first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CNT_OUT_W-1:0] out_sample_count;
  logic signed [STAT_W-1:0] out_mean_q8;
  logic [STAT_W-1:0] out_stddev_q8;
  logic signed [15:0] out_min_sample;
  logic signed [15:0] out_max_sample;
  logic [CNT_OUT_W-1:0] out_in_band_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  sliding_window_statistics dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_clear_first(in_clear_first),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_count(out_sample_count), .out_mean_q8(out_mean_q8),
    .out_stddev_q8(out_stddev_q8), .out_min_sample(out_min_sample),
    .out_max_sample(out_max_sample), .out_in_band_count(out_in_band_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [6:0]  cnt;
    logic [23:0] mean;
    logic [23:0] sd;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [6:0]  band;
  } stats_t;

  // Window model state and register shadows
  logic signed [15:0] win [DEPTH];
  int unsigned head;
  int unsigned fill;
  logic [6:0] wlen_reg;
  logic signed [15:0] blo_reg, bhi_reg;

  stats_t stats_q[$];
  int errors = 0;
  bit rx_hold = 1'b0;
  bit tx_done = 1'b0;
  bit no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Update the window with one sample and compute the statistics after it
  function automatic stats_t window_update(logic signed [15:0] s, logic clr);
    stats_t r;
    int unsigned len, n, ib;
    longint sum, mean;
    longint signed v, lo, hi;
    logic [127:0] sumsq, num;
    len = wlen_reg;
    if (len == 0) len = 1;
    if (len > DEPTH) len = DEPTH;
    if (clr) begin
      head = 0;
      fill = 0;
    end
    while (fill >= len) begin
      head = (head + 1) % DEPTH;
      fill--;
    end
    win[(head + fill) % DEPTH] = s;
    fill++;
    n = fill;
    sum = 0;
    sumsq = 0;
    ib = 0;
    lo = win[head];
    hi = lo;
    for (int i = 0; i < n; i++) begin
      v = win[(head + i) % DEPTH];
      sum += v;
      sumsq += 128'(v * v);
      if (v < lo) lo = v;
      if (v > hi) hi = v;
      if (v > blo_reg && v < bhi_reg) ib++;
    end
    if (sum >= 0) mean = (sum * 256) / n;
    else mean = -(((-sum) * 256 + n - 1) / n);
    num = (128'(n) * sumsq - 128'(sum * sum)) << 16;
    num = num / (128'(n) * n);
    r.cnt = 7'(n);
    r.mean = 24'(mean);
    r.sd = 24'(isqrt(num[63:0]));
    r.lo = 16'(lo);
    r.hi = 16'(hi);
    r.band = 7'(ib);
    return r;
  endfunction

  task automatic wait_idle();
    while (stats_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WLEN:    wlen_reg = val[6:0];
      REG_BAND_LO: blo_reg = val[15:0];
      default:     bhi_reg = val[15:0];
    endcase
  endtask

  task automatic send(logic signed [15:0] s, logic clr);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_clear_first <= clr;
    stats_q = {stats_q, window_update(s, clr)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    wait_idle();
  endtask

  // Directed rows; the first few carry expectations read straight off
  typedef struct {
    logic signed [15:0] s;
    logic clr;
    bit known;
    stats_t want;
  } row_t;

  row_t dir_tab[] = '{
    '{16'sh7FFF, 1'b0, 1'b1, '{7'd1, 24'h7FFF00, 24'd0, 16'h7FFF, 16'h7FFF, 7'd0}},
    '{16'sh8000, 1'b1, 1'b1, '{7'd1, 24'h800000, 24'd0, 16'h8000, 16'h8000, 7'd0}},
    '{16'sh0000, 1'b1, 1'b1, '{7'd1, 24'd0, 24'd0, 16'h0000, 16'h0000, 7'd1}},
    '{16'sh7FFF, 1'b0, 1'b0, '0},
    '{16'sh8000, 1'b0, 1'b0, '0},
    '{16'sh0001, 1'b0, 1'b0, '0},
    '{16'shFFFF, 1'b0, 1'b0, '0},
    '{16'sh5555, 1'b0, 1'b0, '0},
    '{16'shAAAA, 1'b0, 1'b0, '0},
    '{16'sh7FFE, 1'b0, 1'b0, '0},
    '{16'sh8001, 1'b0, 1'b0, '0}
  };

  // Result side: random stalls plus one long hold-off
  initial begin
    stats_t want;
    @(posedge rst_n);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 38);
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = stats_q.pop_front();
          if (out_sample_count !== want.cnt) begin
            $error("sample_count exp %0d got %0d", want.cnt, out_sample_count);
            errors++;
          end
          if (out_mean_q8 !== want.mean) begin
            $error("mean_q8 exp %h got %h", want.mean, out_mean_q8);
            errors++;
          end
          if (out_stddev_q8 !== want.sd) begin
            $error("stddev_q8 exp %h got %h", want.sd, out_stddev_q8);
            errors++;
          end
          if (out_min_sample !== want.lo) begin
            $error("min_sample exp %h got %h", want.lo, out_min_sample);
            errors++;
          end
          if (out_max_sample !== want.hi) begin
            $error("max_sample exp %h got %h", want.hi, out_max_sample);
            errors++;
          end
          if (out_in_band_count !== want.band) begin
            $error("in_band_count exp %0d got %0d", want.band, out_in_band_count);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int k, sel;
    logic signed [15:0] s;
    head = 0;
    fill = 0;
    wlen_reg = WLEN_RESET;
    blo_reg = BAND_LO_RESET;
    bhi_reg = BAND_HI_RESET;
    for (int i = 0; i < DEPTH; i++) win[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at reset settings
    foreach (dir_tab[i]) begin
      send(dir_tab[i].s, dir_tab[i].clr);
      if (dir_tab[i].known && stats_q[$] !== dir_tab[i].want) begin
        $error("directed row %0d: table expectation differs from model", i);
        errors++;
      end
    end
    go_quiet();

    // Window length special cases: zero, above depth, lowered below the current fill
    cfg_write(REG_WLEN, 32'd0);
    send(16'sd100, 1'b0);
    send(-16'sd7, 1'b0);
    go_quiet();
    cfg_write(REG_WLEN, 32'h7F);
    for (int i = 0; i < 4; i++) send(16'(i * 1000), 1'b0);
    go_quiet();
    cfg_write(REG_WLEN, 32'd3);
    cfg_write(REG_BAND_LO, 32'h0000_0010);
    cfg_write(REG_BAND_HI, 32'h0000_0010);
    send(16'sd16, 1'b0);
    send(16'sd17, 1'b0);
    go_quiet();

    // Random phases through several register settings
    k = 0;
    while (k < N_RANDOM) begin
      sel = $urandom_range(5);
      cfg_write(REG_WLEN, (sel == 0) ? 32'd1 : (sel == 1) ? 32'd64 :
                           (sel == 2) ? 32'h7F : $urandom_range(2, 16));
      if ($urandom_range(1)) begin
        cfg_write(REG_BAND_LO, $urandom);
        cfg_write(REG_BAND_HI, $urandom);
      end else begin
        cfg_write(REG_BAND_LO, 32'(-$urandom_range(2000)));
        cfg_write(REG_BAND_HI, 32'($urandom_range(2000)));
      end
      no_idle = (k >= 600 && k < 800);
      if (k >= 1000 && k < 1100) rx_hold = 1'b1;
      for (int j = 0; j < 150; j++) begin
        case ($urandom_range(3))
          0: s = 16'($urandom);
          1: s = 16'($signed($urandom_range(4000)) - 2000);
          2: s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
          default: s = 16'($urandom_range(255)) - 16'sd128;
        endcase
        send(s, ($urandom_range(49) == 0));
        k++;
      end
      go_quiet();
    end
    no_idle = 1'b0;
    tx_done = 1'b1;
  end

  // End of run
  initial begin
    wait (tx_done);
    wait_idle();
    if (errors == 0 && stats_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
